@@ hdl/rcorc_pkg.sv @@
// ============================================================================
// rcorc_pkg - shared types and constants for the row/column occupancy checker
// Command codes, field widths, count limits and the control state encoding.
// ============================================================================
package rcorc_pkg;

    // Width of a coordinate and of a reference count
    localparam int COORD_W = 11;
    localparam int CNT_W   = 11;

    // Largest coordinate an 11-bit field can carry
    localparam int COORD_MAX = 2047;

    // Saturation value of a reference count
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Occupancy bitmap word geometry
    localparam int OCC_W  = 32;
    localparam int OCC_BW = 5;
    localparam logic [OCC_W-1:0] OCC_ONES = '1;

    // Command codes
    typedef enum logic [1:0] {
        CMD_PLACE  = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // Control states, one-hot
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RMW   = 4'b0100,
        ST_SCAN  = 4'b1000
    } state_t;

endpackage

@@ hdl/row_col_occupancy_range_check.sv @@
// ============================================================================
// row_col_occupancy_range_check - row/column reference counts with range query
// Counts placements per row and per column and answers whether a row range or
// a column range is fully occupied.
// ============================================================================
// Usage:
//   Input channel (s_*): one command per transfer. Place and remove update the
//   count of one row and one column and produce no output transfer. A query
//   produces exactly one m_covered transfer on the output channel (m_*).
//   Config channel (cfg_*): writes board_size; cfg_ready is always high.
//   Write it only while the block is idle.
// Operation:
//   Place / remove / unused command: a read-modify-write of the count
//   memories and occupancy bitmaps (one read, one write port each).
//   Query: a scan of the 32-bit bitmap words spanned by the valid row and
//   column ranges, both sides in parallel; the bitmap read port scans one
//   word per cycle. Each side stops early on its first word with a free bit.
// Reset:
//   aresetn low clears control state; afterwards a clearing pass over
//   min(MAX_SIZE, 2047) count entries zeroes the memories with s_ready held low.
//   Config writes are taken during the pass.
// Backpressure:
//   The result sits in an output register. New commands are taken while it
//   waits; a following query holds its answer until the register frees up.
// ============================================================================
module row_col_occupancy_range_check
    import rcorc_pkg::*;
#(
    parameter int MAX_SIZE = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COORD_W-1:0] cfg_board_size,
    // command input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [COORD_W-1:0] s_row_start,
    input  logic [COORD_W-1:0] s_col_start,
    input  logic [COORD_W-1:0] s_row_end,
    input  logic [COORD_W-1:0] s_col_end,
    // query result
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_covered
);

    // Coordinates above 2047 cannot be addressed, so cap the storage there
    localparam int DEPTH = (MAX_SIZE < COORD_MAX) ? MAX_SIZE : COORD_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = (DEPTH + OCC_W - 1) / OCC_W;
    localparam int WAW   = (NW > 1) ? $clog2(NW) : 1;
    localparam logic [COORD_W-1:0] DEPTH_C = COORD_W'(DEPTH);
    localparam logic [AW-1:0]      CLR_LAST = AW'(DEPTH - 1);

    // ------------------------------------------------------------------
    // Storage: counts and occupancy bitmaps, one read and one write port
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] row_cnt_mem [DEPTH];
    logic [CNT_W-1:0] col_cnt_mem [DEPTH];
    logic [OCC_W-1:0] row_occ_mem [NW];
    logic [OCC_W-1:0] col_occ_mem [NW];

    logic [CNT_W-1:0] row_cnt_rd_reg, col_cnt_rd_reg;
    logic [OCC_W-1:0] row_occ_rd_reg, col_occ_rd_reg;

    logic [AW-1:0]    row_cnt_ra, col_cnt_ra, row_cnt_wa, col_cnt_wa;
    logic [CNT_W-1:0] row_cnt_wd, col_cnt_wd;
    logic             row_cnt_we, col_cnt_we;
    logic [WAW-1:0]   row_occ_ra, col_occ_ra, row_occ_wa, col_occ_wa;
    logic [OCC_W-1:0] row_occ_wd, col_occ_wd;
    logic             row_occ_we, col_occ_we;

    // ------------------------------------------------------------------
    // Control and payload registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [COORD_W-1:0]  board_size_reg;

    logic                cmd_up_reg, cmd_up_next;
    logic                row_act_reg, row_act_next;
    logic                col_act_reg, col_act_next;
    logic [COORD_W-1:0]  row_k_reg, row_k_next;     // first row minus one
    logic [COORD_W-1:0]  col_k_reg, col_k_next;
    logic [COORD_W-1:0]  row_hk_reg, row_hk_next;   // last row minus one
    logic [COORD_W-1:0]  col_hk_reg, col_hk_next;
    logic [WAW-1:0]      row_ptr_reg, row_ptr_next;
    logic [WAW-1:0]      col_ptr_reg, col_ptr_next;
    logic                row_ok_reg, row_ok_next;
    logic                col_ok_reg, col_ok_next;
    logic                row_done_reg, row_done_next;
    logic                col_done_reg, col_done_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_covered_reg, m_covered_next;

    // ------------------------------------------------------------------
    // Decode of the incoming command
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] lim;
    logic [COORD_W-1:0] rs_k, cs_k, re_k, ce_k;
    logic               row_c_ok, col_c_ok, row_q_ok, col_q_ok;
    logic               s_xfer, is_bump;

    // Effective board size: board_size clamped to the storage depth
    assign lim = (board_size_reg > DEPTH_C) ? DEPTH_C : board_size_reg;

    assign rs_k = s_row_start - COORD_W'(1);
    assign cs_k = s_col_start - COORD_W'(1);
    assign re_k = s_row_end - COORD_W'(1);
    assign ce_k = s_col_end - COORD_W'(1);

    // A single coordinate is in use when it lies in 1..lim
    assign row_c_ok = (s_row_start != '0) && (s_row_start <= lim);
    assign col_c_ok = (s_col_start != '0) && (s_col_start <= lim);

    // A range can be covered only if ordered and fully on the board
    assign row_q_ok = row_c_ok && (s_row_start <= s_row_end) && (s_row_end <= lim);
    assign col_q_ok = col_c_ok && (s_col_start <= s_col_end) && (s_col_end <= lim);

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign is_bump = (s_command == CMD_PLACE) || (s_command == CMD_REMOVE);

    // ------------------------------------------------------------------
    // Read-modify-write of one count and its occupancy bit
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] row_cnt_new, col_cnt_new;
    logic [OCC_W-1:0] row_occ_new, col_occ_new;

    always_comb begin
        if (cmd_up_reg) begin
            row_cnt_new = (row_cnt_rd_reg == CNT_MAX) ? row_cnt_rd_reg
                                                      : row_cnt_rd_reg + CNT_W'(1);
            col_cnt_new = (col_cnt_rd_reg == CNT_MAX) ? col_cnt_rd_reg
                                                      : col_cnt_rd_reg + CNT_W'(1);
        end else begin
            row_cnt_new = (row_cnt_rd_reg == '0) ? row_cnt_rd_reg
                                                 : row_cnt_rd_reg - CNT_W'(1);
            col_cnt_new = (col_cnt_rd_reg == '0) ? col_cnt_rd_reg
                                                 : col_cnt_rd_reg - CNT_W'(1);
        end
        row_occ_new = row_occ_rd_reg;
        row_occ_new[row_k_reg[OCC_BW-1:0]] = (row_cnt_new != '0);
        col_occ_new = col_occ_rd_reg;
        col_occ_new[col_k_reg[OCC_BW-1:0]] = (col_cnt_new != '0);
    end

    // ------------------------------------------------------------------
    // Query scan: masked AND over one bitmap word per cycle and side
    // ------------------------------------------------------------------
    logic [WAW-1:0]   row_lo_w, row_hi_w, col_lo_w, col_hi_w;
    logic [OCC_W-1:0] row_mask, col_mask;
    logic             row_hit, col_hit;

    assign row_lo_w = WAW'(row_k_reg[COORD_W-1:OCC_BW]);
    assign row_hi_w = WAW'(row_hk_reg[COORD_W-1:OCC_BW]);
    assign col_lo_w = WAW'(col_k_reg[COORD_W-1:OCC_BW]);
    assign col_hi_w = WAW'(col_hk_reg[COORD_W-1:OCC_BW]);

    always_comb begin
        row_mask = OCC_ONES;
        if (row_ptr_reg == row_lo_w) begin
            row_mask = row_mask & (OCC_ONES << row_k_reg[OCC_BW-1:0]);
        end
        if (row_ptr_reg == row_hi_w) begin
            row_mask = row_mask & (OCC_ONES >> (OCC_BW'(OCC_W - 1) - row_hk_reg[OCC_BW-1:0]));
        end
        col_mask = OCC_ONES;
        if (col_ptr_reg == col_lo_w) begin
            col_mask = col_mask & (OCC_ONES << col_k_reg[OCC_BW-1:0]);
        end
        if (col_ptr_reg == col_hi_w) begin
            col_mask = col_mask & (OCC_ONES >> (OCC_BW'(OCC_W - 1) - col_hk_reg[OCC_BW-1:0]));
        end
    end

    assign row_hit = ((row_occ_rd_reg & row_mask) == row_mask);
    assign col_hit = ((col_occ_rd_reg & col_mask) == col_mask);

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cmd_up_next    = cmd_up_reg;
        row_act_next   = row_act_reg;
        col_act_next   = col_act_reg;
        row_k_next     = row_k_reg;
        col_k_next     = col_k_reg;
        row_hk_next    = row_hk_reg;
        col_hk_next    = col_hk_reg;
        row_ptr_next   = row_ptr_reg;
        col_ptr_next   = col_ptr_reg;
        row_ok_next    = row_ok_reg;
        col_ok_next    = col_ok_reg;
        row_done_next  = row_done_reg;
        col_done_next  = col_done_reg;
        m_covered_next = m_covered_reg;

        // drop the result once the receiver takes it
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    cmd_up_next   = (s_command == CMD_PLACE);
                    row_act_next  = is_bump && row_c_ok;
                    col_act_next  = is_bump && col_c_ok;
                    row_k_next    = rs_k;
                    col_k_next    = cs_k;
                    row_hk_next   = re_k;
                    col_hk_next   = ce_k;
                    row_ptr_next  = WAW'(rs_k[COORD_W-1:OCC_BW]);
                    col_ptr_next  = WAW'(cs_k[COORD_W-1:OCC_BW]);
                    row_ok_next   = row_q_ok;
                    col_ok_next   = col_q_ok;
                    row_done_next = !row_q_ok;
                    col_done_next = !col_q_ok;
                    state_next    = (s_command == CMD_QUERY) ? ST_SCAN : ST_RMW;
                end
            end
            ST_RMW: begin
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (row_done_reg && col_done_reg) begin
                    // hold the answer until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_next   = 1'b1;
                        m_covered_next = row_ok_reg || col_ok_reg;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    if (!row_done_reg) begin
                        row_ok_next   = row_ok_reg && row_hit;
                        row_done_next = (row_ptr_reg == row_hi_w) || !row_hit;
                        row_ptr_next  = row_ptr_reg + WAW'(1);
                    end
                    if (!col_done_reg) begin
                        col_ok_next   = col_ok_reg && col_hit;
                        col_done_next = (col_ptr_reg == col_hi_w) || !col_hit;
                        col_ptr_next  = col_ptr_reg + WAW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Memory port control
    // ------------------------------------------------------------------
    always_comb begin
        // count reads only matter for the cycle after a transfer
        row_cnt_ra = AW'(rs_k);
        col_cnt_ra = AW'(cs_k);

        // bitmap read follows the scan pointer, or the start word on a transfer
        row_occ_ra = (state_reg == ST_IDLE) ? WAW'(rs_k[COORD_W-1:OCC_BW]) : row_ptr_next;
        col_occ_ra = (state_reg == ST_IDLE) ? WAW'(cs_k[COORD_W-1:OCC_BW]) : col_ptr_next;

        row_cnt_we = 1'b0;
        col_cnt_we = 1'b0;
        row_occ_we = 1'b0;
        col_occ_we = 1'b0;
        row_cnt_wa = AW'(row_k_reg);
        col_cnt_wa = AW'(col_k_reg);
        row_cnt_wd = row_cnt_new;
        col_cnt_wd = col_cnt_new;
        row_occ_wa = row_lo_w;
        col_occ_wa = col_lo_w;
        row_occ_wd = row_occ_new;
        col_occ_wd = col_occ_new;

        if (state_reg == ST_CLEAR) begin
            row_cnt_we = 1'b1;
            col_cnt_we = 1'b1;
            row_cnt_wa = clr_cnt_reg;
            col_cnt_wa = clr_cnt_reg;
            row_cnt_wd = '0;
            col_cnt_wd = '0;
            row_occ_we = (32'(clr_cnt_reg) < 32'(NW));
            col_occ_we = (32'(clr_cnt_reg) < 32'(NW));
            row_occ_wa = WAW'(clr_cnt_reg);
            col_occ_wa = WAW'(clr_cnt_reg);
            row_occ_wd = '0;
            col_occ_wd = '0;
        end else if (state_reg == ST_RMW) begin
            row_cnt_we = row_act_reg;
            col_cnt_we = col_act_reg;
            row_occ_we = row_act_reg;
            col_occ_we = col_act_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (row_cnt_we) begin
            row_cnt_mem[row_cnt_wa] <= row_cnt_wd;
        end
        row_cnt_rd_reg <= row_cnt_mem[row_cnt_ra];
    end

    always_ff @(posedge aclk) begin
        if (col_cnt_we) begin
            col_cnt_mem[col_cnt_wa] <= col_cnt_wd;
        end
        col_cnt_rd_reg <= col_cnt_mem[col_cnt_ra];
    end

    always_ff @(posedge aclk) begin
        if (row_occ_we) begin
            row_occ_mem[row_occ_wa] <= row_occ_wd;
        end
        row_occ_rd_reg <= row_occ_mem[row_occ_ra];
    end

    always_ff @(posedge aclk) begin
        if (col_occ_we) begin
            col_occ_mem[col_occ_wa] <= col_occ_wd;
        end
        col_occ_rd_reg <= col_occ_mem[col_occ_ra];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            board_size_reg <= DEPTH_C == COORD_W'(COORD_MAX) ? COORD_W'(1024) : COORD_W'(1024);
            m_valid_reg    <= 1'b0;
            row_done_reg   <= 1'b1;
            col_done_reg   <= 1'b1;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_valid_reg  <= m_valid_next;
            row_done_reg <= row_done_next;
            col_done_reg <= col_done_next;
            if (cfg_valid && cfg_ready) begin
                board_size_reg <= cfg_board_size;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        cmd_up_reg    <= cmd_up_next;
        row_act_reg   <= row_act_next;
        col_act_reg   <= col_act_next;
        row_k_reg     <= row_k_next;
        col_k_reg     <= col_k_next;
        row_hk_reg    <= row_hk_next;
        col_hk_reg    <= col_hk_next;
        row_ptr_reg   <= row_ptr_next;
        col_ptr_reg   <= col_ptr_next;
        row_ok_reg    <= row_ok_next;
        col_ok_reg    <= col_ok_next;
        m_covered_reg <= m_covered_next;
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_covered = m_covered_reg;

endmodule

@@ hdl/rcorc_checker.sv @@
// ============================================================================
// rcorc_checker - port-level checks for row_col_occupancy_range_check
// Watches the handshakes and the reset sequence seen at the top level.
// ============================================================================
module rcorc_checker
    import rcorc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_command,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_covered
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_covered))
        else $error("stalled result changed or dropped");

    // The clearing pass blocks input right after reset
    a_clear_blocks: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_ready)
        else $error("input accepted before clearing pass");

    // A taken command always drops s_ready before the next command can be taken
    a_two_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command accepted on consecutive cycles");

    // Place and remove never raise a result
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid &&
        (s_command == CMD_PLACE || s_command == CMD_REMOVE) |=> !m_valid)
        else $error("result produced by place or remove");

    // No result comes out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind row_col_occupancy_range_check rcorc_checker u_rcorc_checker (.*);
